// ----- hw/rtl/topp_pkg.sv -----
package topp_pkg;

  // default parameter values
  localparam int TAB_STOP_DEF    = 8;
  localparam int COLUMN_BITS_DEF = 16;

  // most result items one request may cause
  localparam int MAX_RESULTS = 8;

  // plan queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_POST_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_NEWLINE_TO_CRLF = 3'd1;
  localparam logic [2:0] CFG_CR_TO_NEWLINE   = 3'd2;
  localparam logic [2:0] CFG_NO_CR_AT_COL0   = 3'd3;
  localparam logic [2:0] CFG_NEWLINE_RETURNS = 3'd4;
  localparam logic [2:0] CFG_EXPAND_TABS     = 3'd5;
  localparam logic [2:0] CFG_LOWER_TO_UPPER  = 3'd6;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic [11:0] room;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        retry;
    logic        last;
    logic [15:0] cursor_column;
    logic [15:0] line_start_column;
  } out_item_t;

  typedef struct packed {
    logic post_enable;
    logic newline_to_crlf;
    logic cr_to_newline;
    logic no_cr_at_col0;
    logic newline_returns;
    logic expand_tabs;
    logic lower_to_upper;
  } cfg_t;

  // what the back emits for one request: optional leading cr, then rep copies
  typedef struct packed {
    logic        lead_cr;
    logic [7:0]  main_byte;
    logic        main_valid;
    logic        retry;
    logic [3:0]  rep;
    logic [15:0] cursor_column;
    logic [15:0] line_start_column;
  } plan_t;

  // handshake between queue and its neighbours
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_ctl_t;

endpackage

// ----- hw/rtl/terminal_output_postprocess.sv -----
// channel   direction  payload                         handshake
// in_       in         in_data  (in_item_t)            in_valid / in_ready
// out_      out        out_data (out_item_t)           out_valid / out_ready
// cfg_      in         cfg_index (3b), cfg_data (1b)   cfg_valid / cfg_ready (always high)
//
// one request enters per cycle while the plan queue has room; the front updates the
// columns as it accepts, so requests follow one another with no gap
// the back emits one result per cycle while out_ready holds: one for most requests, two for cr lf, up to
// eight for an expanded tab, so the sustained rate is set by the output register
// synchronous active-low reset clears columns, queue and output; registers take defaults
// a stalled output fills the queue (four plans deep) and only then drops in_ready
module terminal_output_postprocess #(
  parameter int TAB_STOP    = topp_pkg::TAB_STOP_DEF,
  parameter int COLUMN_BITS = topp_pkg::COLUMN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  topp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output topp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic                cfg_data
);
  import topp_pkg::*;

  // plans travel from front to back through the queue
  plan_t     front_plan, head_plan;
  q_wr_ctl_t wr_ctl;
  q_rd_ctl_t rd_ctl;
  logic      q_full, q_empty, q_pop, front_push;

  // registers are always writable; the user must make writes land only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  topp_front #(
    .TAB_STOP    (TAB_STOP),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (front_push),
    .q_plan    (front_plan)
  );

  assign wr_ctl.push = front_push;
  assign wr_ctl.full = q_full;

  topp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_ctl  (wr_ctl),
    .wr_plan (front_plan),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (head_plan)
  );

  assign rd_ctl.pop   = q_pop;
  assign rd_ctl.empty = q_empty;

  topp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_ctl    (rd_ctl),
    .head      (head_plan),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/topp_front.sv -----
module topp_front #(
  parameter int TAB_STOP    = topp_pkg::TAB_STOP_DEF,
  parameter int COLUMN_BITS = topp_pkg::COLUMN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  topp_pkg::in_item_t in_data,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic               cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output topp_pkg::plan_t    q_plan
);
  import topp_pkg::*;

  localparam int PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int SP_W = $clog2(TAB_STOP + 1);
  localparam int CW1  = COLUMN_BITS + 1;
  // column mod tab stop just after a tab wraps the column
  localparam longint unsigned COL_MOD = 64'd1 << COLUMN_BITS;
  localparam int WRAP_PHASE = int'((TAB_STOP - (COL_MOD % TAB_STOP)) % TAB_STOP);

  cfg_t cfg_r;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [COLUMN_BITS-1:0] line_r, line_nxt;
  logic [PH_W-1:0]        phase_r, phase_nxt;   // col_r mod tab stop

  logic            accept;
  logic [SP_W-1:0] spaces;
  logic [CW1-1:0]  tab_sum, inc_sum;
  logic [COLUMN_BITS-1:0] base_col;
  logic [PH_W-1:0] base_phase, tab_phase, inc_phase;
  logic [7:0]      mapped;
  logic            is_ctrl;
  logic [31:0]     col_ext, line_ext;
  plan_t           plan;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    spaces   = SP_W'(TAB_STOP) - SP_W'(phase_r);
    tab_sum  = {1'b0, col_r} + CW1'(spaces);
    tab_phase = tab_sum[COLUMN_BITS] ? PH_W'(WRAP_PHASE) : '0;
    inc_sum  = {1'b0, col_r} + CW1'(1);
    if (inc_sum[COLUMN_BITS] || phase_r == PH_W'(TAB_STOP - 1)) begin
      inc_phase = '0;
    end else begin
      inc_phase = phase_r + PH_W'(1);
    end
    base_col   = cfg_r.newline_returns ? '0 : col_r;
    base_phase = cfg_r.newline_returns ? '0 : phase_r;
    mapped = in_data.in_byte;
    if (cfg_r.lower_to_upper && in_data.in_byte >= CH_LOW_A && in_data.in_byte <= CH_LOW_Z) begin
      mapped = in_data.in_byte - CASE_GAP;
    end
    is_ctrl = (mapped < CH_SPACE) || (mapped == CH_DEL);

    col_nxt   = col_r;
    line_nxt  = line_r;
    phase_nxt = phase_r;
    plan.lead_cr    = 1'b0;
    plan.main_byte  = in_data.in_byte;
    plan.main_valid = 1'b1;
    plan.retry      = 1'b0;
    plan.rep        = 4'd1;

    if (in_data.room == 12'd0) begin
      plan.main_byte  = CH_NUL;
      plan.main_valid = 1'b0;
      plan.retry      = 1'b1;
    end else if (cfg_r.post_enable) begin
      unique case (in_data.in_byte)
        CH_LF: begin
          if (cfg_r.newline_to_crlf) begin
            if (in_data.room < 12'd2) begin
              // the column reset already done is kept
              col_nxt         = base_col;
              phase_nxt       = base_phase;
              plan.main_byte  = CH_NUL;
              plan.main_valid = 1'b0;
              plan.retry      = 1'b1;
            end else begin
              plan.lead_cr = 1'b1;
              col_nxt      = '0;
              phase_nxt    = '0;
              line_nxt     = '0;
            end
          end else begin
            col_nxt   = base_col;
            phase_nxt = base_phase;
            line_nxt  = base_col;
          end
        end
        CH_CR: begin
          if (cfg_r.no_cr_at_col0 && col_r == '0) begin
            plan.main_byte  = CH_NUL;
            plan.main_valid = 1'b0;
          end else if (cfg_r.cr_to_newline) begin
            plan.main_byte = CH_LF;
            if (cfg_r.newline_returns) begin
              col_nxt   = '0;
              phase_nxt = '0;
              line_nxt  = '0;
            end
          end else begin
            col_nxt   = '0;
            phase_nxt = '0;
            line_nxt  = '0;
          end
        end
        CH_TAB: begin
          if (cfg_r.expand_tabs) begin
            if (in_data.room < 12'(spaces)) begin
              plan.main_byte  = CH_NUL;
              plan.main_valid = 1'b0;
              plan.retry      = 1'b1;
            end else begin
              col_nxt        = tab_sum[COLUMN_BITS-1:0];
              phase_nxt      = tab_phase;
              plan.main_byte = CH_SPACE;
              plan.rep       = (32'(spaces) > 32'(MAX_RESULTS)) ? 4'(MAX_RESULTS)
                                                                 : 4'(spaces);
            end
          end else begin
            col_nxt   = tab_sum[COLUMN_BITS-1:0];
            phase_nxt = tab_phase;
          end
        end
        CH_BS: begin
          if (col_r != '0) begin
            col_nxt   = col_r - COLUMN_BITS'(1);
            phase_nxt = (phase_r == '0) ? PH_W'(TAB_STOP - 1) : phase_r - PH_W'(1);
          end
        end
        default: begin
          plan.main_byte = mapped;
          if (!is_ctrl) begin
            col_nxt   = inc_sum[COLUMN_BITS-1:0];
            phase_nxt = inc_phase;
          end
        end
      endcase
    end

    col_ext  = 32'(col_nxt);
    line_ext = 32'(line_nxt);
    plan.cursor_column     = col_ext[15:0];
    plan.line_start_column = line_ext[15:0];
  end

  assign q_push = accept;
  assign q_plan = plan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      line_r  <= '0;
      phase_r <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.post_enable     <= 1'b1;
      cfg_r.newline_to_crlf <= 1'b1;
      cfg_r.cr_to_newline   <= 1'b0;
      cfg_r.no_cr_at_col0   <= 1'b0;
      cfg_r.newline_returns <= 1'b0;
      cfg_r.expand_tabs     <= 1'b0;
      cfg_r.lower_to_upper  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POST_ENABLE:     cfg_r.post_enable     <= cfg_data;
        CFG_NEWLINE_TO_CRLF: cfg_r.newline_to_crlf <= cfg_data;
        CFG_CR_TO_NEWLINE:   cfg_r.cr_to_newline   <= cfg_data;
        CFG_NO_CR_AT_COL0:   cfg_r.no_cr_at_col0   <= cfg_data;
        CFG_NEWLINE_RETURNS: cfg_r.newline_returns <= cfg_data;
        CFG_EXPAND_TABS:     cfg_r.expand_tabs     <= cfg_data;
        CFG_LOWER_TO_UPPER:  cfg_r.lower_to_upper  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/topp_queue.sv -----
module topp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  topp_pkg::q_wr_ctl_t wr_ctl,
  input  topp_pkg::plan_t     wr_plan,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output topp_pkg::plan_t     head
);
  import topp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  plan_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = count_r == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = wr_ctl.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_plan;
    end
  end

endmodule

// ----- hw/rtl/topp_back.sv -----
module topp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  topp_pkg::q_rd_ctl_t rd_ctl,
  input  topp_pkg::plan_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output topp_pkg::out_item_t out_data
);
  import topp_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic [3:0] total;
  logic       last_step, load;
  logic       out_valid_r;
  out_item_t  out_r, item;

  assign total     = 4'(head.lead_cr) + head.rep;
  assign last_step = step_r == total - 4'd1;
  assign load      = !rd_ctl.empty && (!out_valid_r || out_ready);
  assign pop       = load && last_step;
  assign step_nxt  = last_step ? 4'd0 : step_r + 4'd1;

  always_comb begin
    item.out_byte          = (head.lead_cr && step_r == 4'd0) ? CH_CR : head.main_byte;
    item.byte_valid        = head.main_valid || (head.lead_cr && step_r == 4'd0);
    item.retry             = head.retry;
    item.last              = last_step;
    item.cursor_column     = head.cursor_column;
    item.line_start_column = head.line_start_column;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r      <= step_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- tb/sv/tb_terminal_output_postprocess.sv -----
`timescale 1ns / 100ps

module tb_terminal_output_postprocess;
  import topp_pkg::*;

  localparam int TAB_STOP      = TAB_STOP_DEF;
  localparam int SETTLE_CYCLES = 8;      // output register plus plan queue
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 30;     // about 210 requests in all with the directed ones

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = CFG_POST_ENABLE;
  logic      cfg_data  = 1'b0;

  // predicted view of the block
  cfg_t        modes;
  logic [15:0] col_now;
  logic [15:0] line_col;
  out_item_t   expected_q[$];

  int mismatch_count = 0;
  int burst_left     = 0;
  bit sender_steady  = 1'b0;
  int cycle_count    = 0;
  int stall_left     = 0;

  terminal_output_postprocess dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // scoreboard helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // a blank result: retry or dropped carriage return
  function automatic out_item_t bare_result(input logic retry_flag);
    out_item_t r;
    r = '0;
    r.retry = retry_flag;
    return r;
  endfunction

  function automatic out_item_t byte_result(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  // register write as seen on the config port
  task automatic apply_setting(input logic [2:0] idx, input logic val);
    case (idx)
      CFG_POST_ENABLE:     modes.post_enable     = val;
      CFG_NEWLINE_TO_CRLF: modes.newline_to_crlf = val;
      CFG_CR_TO_NEWLINE:   modes.cr_to_newline   = val;
      CFG_NO_CR_AT_COL0:   modes.no_cr_at_col0   = val;
      CFG_NEWLINE_RETURNS: modes.newline_returns = val;
      CFG_EXPAND_TABS:     modes.expand_tabs     = val;
      CFG_LOWER_TO_UPPER:  modes.lower_to_upper  = val;
      default: ;
    endcase
  endtask

  // works out the line bytes and columns one request causes
  task automatic predict_output(input in_item_t req);
    out_item_t   emitted[$];
    logic [7:0]  ch;
    int unsigned gap;
    int unsigned copies;
    bit          send_main;
    ch        = req.in_byte;
    send_main = 1'b1;
    if (req.room == 0) begin
      // no room at all: retry whatever the mode
      emitted.push_back(bare_result(1'b1));
      send_main = 1'b0;
    end else if (modes.post_enable) begin
      case (ch)
        CH_LF: begin
          // the column reset happens before the room check and survives a retry
          if (modes.newline_returns) col_now = '0;
          if (modes.newline_to_crlf && req.room < 2) begin
            emitted.push_back(bare_result(1'b1));
            send_main = 1'b0;
          end else begin
            if (modes.newline_to_crlf) begin
              emitted.push_back(byte_result(CH_CR));
              col_now = '0;
            end
            line_col = col_now;
          end
        end
        CH_CR: begin
          if (modes.no_cr_at_col0 && col_now == 0) begin
            emitted.push_back(bare_result(1'b0));
            send_main = 1'b0;
          end else if (modes.cr_to_newline) begin
            ch = CH_LF;
            if (modes.newline_returns) begin
              col_now  = '0;
              line_col = '0;
            end
          end else begin
            col_now  = '0;
            line_col = '0;
          end
        end
        CH_TAB: begin
          gap = TAB_STOP - (col_now % TAB_STOP);
          if (modes.expand_tabs) begin
            send_main = 1'b0;
            if (req.room < gap) begin
              emitted.push_back(bare_result(1'b1));
            end else begin
              col_now = 16'(col_now + gap);
              copies  = (gap > MAX_RESULTS) ? MAX_RESULTS : gap;
              repeat (copies) emitted.push_back(byte_result(CH_SPACE));
            end
          end else begin
            col_now = 16'(col_now + gap);
          end
        end
        CH_BS: begin
          if (col_now != 0) col_now = col_now - 16'd1;
        end
        default: begin
          if (modes.lower_to_upper && ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_GAP;
          // control bytes hold the column, 0x80 and up count as printable
          if (!(ch < CH_SPACE || ch == CH_DEL)) col_now = col_now + 16'd1;
        end
      endcase
    end
    if (send_main) emitted.push_back(byte_result(ch));
    // every result of the request carries the final columns
    foreach (emitted[i]) begin
      emitted[i].cursor_column     = col_now;
      emitted[i].line_start_column = line_col;
      emitted[i].last              = (i == emitted.size() - 1);
      expected_q.push_back(emitted[i]);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no request pending", got, 0);
    end else begin
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", got.out_byte, want.out_byte);
      if (got.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
      if (got.retry !== want.retry)
        report_mismatch("retry", got.retry, want.retry);
      if (got.last !== want.last)
        report_mismatch("last", got.last, want.last);
      if (got.cursor_column !== want.cursor_column)
        report_mismatch("cursor_column", got.cursor_column, want.cursor_column);
      if (got.line_start_column !== want.line_start_column)
        report_mismatch("line_start_column", got.line_start_column, want.line_start_column);
    end
  endtask

  // one watcher for all three channels; prediction first so ordering is safe
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_output(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // receiver: steady, then scattered stalls, then long stall bursts, in turn
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 150) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          out_ready  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left <= $urandom_range(1, 12);
          out_ready  <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one request, with burst and gap shaping unless the sender is held steady
  task automatic send_request(input logic [7:0] b, input logic [11:0] r);
    int idle;
    if (!sender_steady && burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle != 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.room    <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left != 0) burst_left--;
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // valid stays high across back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [2:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_modes(input cfg_t m);
    wait_idle();
    write_reg(CFG_POST_ENABLE,     m.post_enable);
    write_reg(CFG_NEWLINE_TO_CRLF, m.newline_to_crlf);
    write_reg(CFG_CR_TO_NEWLINE,   m.cr_to_newline);
    write_reg(CFG_NO_CR_AT_COL0,   m.no_cr_at_col0);
    write_reg(CFG_NEWLINE_RETURNS, m.newline_returns);
    write_reg(CFG_EXPAND_TABS,     m.expand_tabs);
    write_reg(CFG_LOWER_TO_UPPER,  m.lower_to_upper);
    cfg_valid <= 1'b0;
  endtask

  // weighted towards the bytes that have rules of their own
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return CH_LF;
      1:       return CH_CR;
      2, 3:    return CH_TAB;
      4:       return CH_BS;
      5, 6:    return 8'($urandom_range(CH_LOW_Z, CH_LOW_A));
      7:       return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // small rooms hit the retry paths, wide ones toggle every bit
  function automatic logic [11:0] pick_room();
    case ($urandom_range(0, 9))
      0:       return 12'd0;
      1:       return 12'd1;
      2, 3:    return 12'($urandom_range(2, 9));
      4, 5:    return 12'($urandom_range(1, 4095));
      6, 7:    return 12'($urandom_range(16, 200));
      default: return 12'd4095;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults straight out of reset: processing and cr lf on
  task automatic test_default_modes();
    send_request(8'h61, 12'd4095);   // printable, column 1
    send_request(CH_NUL, 12'd1);     // control byte holds the column
    send_request(CH_DEL, 12'd1);
    send_request(8'hFF, 12'd4095);   // high bytes count as printable
    send_request(CH_LF, 12'd1);      // cr lf needs two slots: retry
    send_request(CH_LF, 12'd2);      // cr then lf, column back to zero
    send_request(CH_TAB, 12'd1);     // tab not expanded, column to next stop
    send_request(CH_BS, 12'd1);
    send_request(8'h78, 12'd0);      // no room at all
    send_request(CH_CR, 12'd5);
    send_request(CH_BS, 12'd3);      // backspace at column zero stays put
  endtask

  // processing off: every byte goes through untouched
  task automatic test_passthrough();
    set_modes('0);
    send_request(CH_LF, 12'd1);
    send_request(CH_CR, 12'd1);
    send_request(CH_TAB, 12'd1);
    send_request(8'h71, 12'd1);
    send_request(CH_TAB, 12'd0);     // room zero still retries
  endtask

  // dropped cr, case mapping, short room for tabs and newlines, cr as newline
  task automatic test_special_cases();
    cfg_t m;
    m = '1;
    m.cr_to_newline = 1'b0;
    set_modes(m);
    send_request(CH_CR, 12'd9);      // at column zero: dropped, nothing on the line
    send_request(8'h61, 12'd9);      // maps to upper case
    send_request(8'h7A, 12'd9);
    send_request(8'h60, 12'd9);      // just outside the lower-case range
    send_request(8'h7B, 12'd9);
    send_request(CH_TAB, 12'd3);     // four spaces needed: retry
    send_request(CH_TAB, 12'd4);
    send_request(CH_TAB, 12'd8);     // full tab of eight spaces
    send_request(CH_LF, 12'd1);      // retry, but the column reset sticks
    send_request(8'h62, 12'd1);
    m = '1;
    set_modes(m);
    send_request(CH_CR, 12'd1);      // turned into a newline, columns reset
  endtask

  // random modes per phase, random requests within each phase
  task automatic test_random_traffic();
    cfg_t m;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) m = '1;
      else m = cfg_t'(7'($urandom_range(0, 127)));
      set_modes(m);
      sender_steady = (phase == 2);  // a stretch with no sender gaps
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mid-phase pause until everything outstanding has drained
        if (phase == 3 && i == PHASE_ITEMS / 2) wait_idle();
        send_request(pick_byte(), pick_room());
      end
      sender_steady = 1'b0;
    end
  endtask

  initial begin
    modes                 = '0;
    modes.post_enable     = 1'b1;
    modes.newline_to_crlf = 1'b1;
    col_now               = '0;
    line_col              = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_modes();
    test_passthrough();
    test_special_cases();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
